// ===== hw/rtl/alfr_pkg.sv =====
// Shared types, constants and helpers for the additive lagged-Fibonacci generator.
// Used by alfr_div and additive_lagged_fibonacci_rng; no dependencies.
package alfr_pkg;

    localparam int DATA_W      = 32;
    localparam int TABLE_WORDS = 55;
    localparam int LAG_OFFSET  = 20;
    localparam int CONST_MAX   = 64;

    localparam int IDX_W   = $clog2(TABLE_WORDS);
    localparam int IDX1_W  = IDX_W + 1;
    localparam int LAG_WRAP = LAG_OFFSET % TABLE_WORDS;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_WORDS - 1);

    localparam logic [DATA_W-1:0] MUL_PREV   = 32'd1001;
    localparam logic [DATA_W-1:0] MUL_SEED   = 32'd999;
    localparam logic [DATA_W-1:0] TABLE_DIVS = DATA_W'(TABLE_WORDS);

    // serial divider: one quotient bit per cycle
    localparam int DIV_CNT_W = $clog2(DATA_W);
    localparam logic [DIV_CNT_W-1:0] DIV_CNT_LAST = DIV_CNT_W'(DATA_W - 1);

    // seeding constants; words past the list start from zero
    localparam logic [DATA_W-1:0] BASE_WORDS [CONST_MAX] = '{
        32'o35340171546, 32'o10401501101, 32'o22364657325, 32'o24130436022,
        32'o02167303062, 32'o37570375137, 32'o37210607110, 32'o16272055420,
        32'o23011770546, 32'o17143426366, 32'o14753657433, 32'o21657231332,
        32'o23553406142, 32'o04236526362, 32'o10365611275, 32'o07117336710,
        32'o11051276551, 32'o02362132524, 32'o01011540233, 32'o12162531646,
        32'o07056762337, 32'o06631245521, 32'o14164542224, 32'o32633236305,
        32'o23342700176, 32'o02433062234, 32'o15257225043, 32'o26762051606,
        32'o00742573230, 32'o05366042132, 32'o12126416411, 32'o00520471171,
        32'o00725646277, 32'o20116577576, 32'o25765742604, 32'o07633473735,
        32'o15674255275, 32'o17555634041, 32'o06503154145, 32'o21576344247,
        32'o14577627653, 32'o02707523333, 32'o34146376720, 32'o30060227734,
        32'o13765414060, 32'o36072251540, 32'o07255221037, 32'o24364674123,
        32'o06200353166, 32'o10126373326, 32'o15664104320, 32'o16401041535,
        32'o16215305520, 32'o33115351014, 32'o17411670323, 32'o0,
        32'o0, 32'o0, 32'o0, 32'o0, 32'o0, 32'o0, 32'o0, 32'o0
    };

    typedef enum logic [2:0] {
        ST_SEED_WRITE,
        ST_SEED_MIX,
        ST_SEED_DIV,
        ST_IDLE,
        ST_ADD,
        ST_DRAW_DIV,
        ST_FINISH
    } alfr_state_t;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] rem;
    } div_rsp_t;

    // index one step ahead, with wrap
    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] r;
        if (idx == LAST_IDX)
        begin
            r = '0;
        end
        else
        begin
            r = idx + IDX_W'(1);
        end
        return r;
    endfunction

    // trail index: lag offset ahead of lead, with wrap
    function automatic logic [IDX_W-1:0] lag_wrap(input logic [IDX_W-1:0] lead);
        logic [IDX1_W-1:0] t;
        t = {1'b0, lead} + IDX1_W'(LAG_WRAP);
        if (t >= IDX1_W'(TABLE_WORDS))
        begin
            t = t - IDX1_W'(TABLE_WORDS);
        end
        return t[IDX_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/alfr_div.sv =====
// Radix-2 restoring serial divider, remainder only; one bit per cycle.
// Depends on alfr_pkg (widths, request/response structs).
module alfr_div
    import alfr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DATA_W-1:0]    rem_reg, rem_next;
    logic [DATA_W-1:0]    quo_reg, quo_next;
    logic [DATA_W-1:0]    dvs_reg, dvs_next;

    logic [DATA_W:0] trial;
    logic [DATA_W:0] diff;
    logic            fits;

    assign trial = {rem_reg, quo_reg[DATA_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
            quo_next = {quo_reg[DATA_W-2:0], fits};
            cnt_next = cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

endmodule

// ===== hw/rtl/additive_lagged_fibonacci_rng.sv =====
// Top level of the additive lagged-Fibonacci generator: sequencer, lag table, seeding.
// Depends on alfr_pkg and alfr_div.
//
// channel   | signals                              | dir | notes
// ----------+--------------------------------------+-----+------------------------------
// draw      | draw_valid, draw_ready, bound[31:0]  | in  | one item per draw
// result    | result_valid, result_ready, value    | out | registered, one per draw
// cfg       | cfg_we, cfg_wdata[31:0]              | in  | seed register, reseeds table
//
// An item steps through idle, add and finish when bound is 0; otherwise the 32-step
// serial divider runs between add and finish. The result is registered in the finish
// step.
// After reset and after each seed write, the table is reseeded: word 0 is written first,
// then each later word takes a mix step and a write step, and then the same divider finds
// word0 mod 55; draw_ready stays low meanwhile.
// The result register frees the sequencer: a new item is accepted while a
// result waits, and the next result is held back until that one is taken.
module additive_lagged_fibonacci_rng
    import alfr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [DATA_W-1:0] cfg_wdata,
    input  logic              draw_valid,
    output logic              draw_ready,
    input  logic [DATA_W-1:0] bound,
    output logic              result_valid,
    input  logic              result_ready,
    output logic [DATA_W-1:0] value
);

    alfr_state_t state_reg, state_next;

    // seeding chain
    logic [DATA_W-1:0] s_reg, s_next;        // running chain term
    logic [DATA_W-1:0] w_reg, w_next;        // last word written
    logic [DATA_W-1:0] word0_reg, word0_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;

    // draw state
    logic [IDX_W-1:0]  lead_reg, lead_next;
    logic [IDX_W-1:0]  trail_reg, trail_next;
    logic [DATA_W-1:0] bound_reg, bound_next;
    logic [DATA_W-1:0] sum_reg, sum_next;
    logic              result_valid_reg, result_valid_next;
    logic [DATA_W-1:0] value_reg, value_next;

    // lag table, two registered read ports at lead and trail
    logic [DATA_W-1:0] mem [TABLE_WORDS];
    logic [DATA_W-1:0] rd_a_reg;
    logic [DATA_W-1:0] rd_b_reg;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [DATA_W-1:0] mem_wdata;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic [DATA_W-1:0] seed_word;
    logic [DATA_W-1:0] mix;
    logic [DATA_W-1:0] draw_sum;

    assign seed_word = BASE_WORDS[idx_reg] + s_reg;
    // s = prev_word*1001 + s*999, mod 2^32
    assign mix       = w_reg * MUL_PREV + s_reg * MUL_SEED;
    assign draw_sum  = rd_a_reg + rd_b_reg;

    alfr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_SEED_WRITE:
            begin
                state_next = (idx_reg == LAST_IDX) ? ST_SEED_DIV : ST_SEED_MIX;
            end
            ST_SEED_MIX:
            begin
                state_next = ST_SEED_WRITE;
            end
            ST_SEED_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (draw_valid)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                state_next = (bound_reg == '0) ? ST_FINISH : ST_DRAW_DIV;
            end
            ST_DRAW_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        // a seed write restarts seeding from word 0
        if (cfg_we)
        begin
            state_next = ST_SEED_WRITE;
        end
    end

    // datapath and outputs
    always_comb
    begin
        s_next            = s_reg;
        w_next            = w_reg;
        word0_next        = word0_reg;
        idx_next          = idx_reg;
        lead_next         = lead_reg;
        trail_next        = trail_reg;
        bound_next        = bound_reg;
        sum_next          = sum_reg;
        value_next        = value_reg;
        result_valid_next = result_valid_reg;
        mem_we            = 1'b0;
        mem_waddr         = idx_reg;
        mem_wdata         = seed_word;
        div_req.start     = 1'b0;
        div_req.dividend  = word0_reg;
        div_req.divisor   = TABLE_DIVS;
        draw_ready        = 1'b0;

        if (result_ready)
        begin
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_SEED_WRITE:
            begin
                mem_we = 1'b1;
                w_next = seed_word;
                if (idx_reg == '0)
                begin
                    word0_next = seed_word;
                end
                if (idx_reg == LAST_IDX)
                begin
                    div_req.start = 1'b1;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_SEED_MIX:
            begin
                s_next = mix;
            end
            ST_SEED_DIV:
            begin
                if (div_rsp.done)
                begin
                    lead_next  = div_rsp.rem[IDX_W-1:0];
                    trail_next = lag_wrap(div_rsp.rem[IDX_W-1:0]);
                end
            end
            ST_IDLE:
            begin
                draw_ready = 1'b1;
                if (draw_valid)
                begin
                    bound_next = bound;
                end
            end
            ST_ADD:
            begin
                mem_we     = 1'b1;
                mem_waddr  = lead_reg;
                mem_wdata  = draw_sum;
                sum_next   = draw_sum;
                lead_next  = idx_inc(lead_reg);
                trail_next = idx_inc(trail_reg);
                if (bound_reg != '0)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = draw_sum;
                    div_req.divisor  = bound_reg;
                end
            end
            ST_DRAW_DIV:
            begin
            end
            ST_FINISH:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    result_valid_next = 1'b1;
                    value_next = (bound_reg == '0) ? sum_reg : div_rsp.rem;
                end
            end
            default:
            begin
            end
        endcase

        if (cfg_we)
        begin
            s_next    = cfg_wdata;
            idx_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_SEED_WRITE;
            s_reg            <= '0;
            idx_reg          <= '0;
            lead_reg         <= '0;
            trail_reg        <= lag_wrap('0);
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            s_reg            <= s_next;
            idx_reg          <= idx_next;
            lead_reg         <= lead_next;
            trail_reg        <= trail_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg     <= w_next;
        word0_reg <= word0_next;
        bound_reg <= bound_next;
        sum_reg   <= sum_next;
        value_reg <= value_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_a_reg <= mem[lead_reg];
        rd_b_reg <= mem[trail_reg];
    end

    assign result_valid = result_valid_reg;
    assign value        = value_reg;

`ifndef SYNTH
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        draw_ready |-> (lead_reg <= LAST_IDX) && (trail_reg <= LAST_IDX))
        else $error("lag index out of table range");

    a_lag_gap: assert property (@(posedge clk) disable iff (!rst_n)
        draw_ready |-> trail_reg == lag_wrap(lead_reg))
        else $error("trail index lost its lag from lead index");

    a_seed_idx: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= LAST_IDX)
        else $error("seeding counter ran past the table");

    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(state_reg) == ST_FINISH)
        else $error("result raised outside the finish step");
`endif

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for additive_lagged_fibonacci_rng: directed table, then random phases.
// Holds its own model of the lag table and the seeding chain; needs alfr_pkg and the block's RTL.
module testbench;
    import alfr_pkg::*;

    // model sizes, kept apart from the package on purpose
    localparam int N_WORDS   = 55;
    localparam int LAG_AHEAD = 20;

    // longest expected quiet stretch is a reseed plus a sender gap and a full divide;
    // this limit is several times that
    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int TAIL_CYCLES = 40;
    localparam int DIR_ROWS = 21;
    localparam int PHASES = 6;
    localparam int PHASE_ITEMS = 306;

    // seeding constants, word i of the table before the chain is added
    localparam logic [31:0] SEED_WORDS [N_WORDS] = '{
        32'o35340171546, 32'o10401501101, 32'o22364657325, 32'o24130436022,
        32'o02167303062, 32'o37570375137, 32'o37210607110, 32'o16272055420,
        32'o23011770546, 32'o17143426366, 32'o14753657433, 32'o21657231332,
        32'o23553406142, 32'o04236526362, 32'o10365611275, 32'o07117336710,
        32'o11051276551, 32'o02362132524, 32'o01011540233, 32'o12162531646,
        32'o07056762337, 32'o06631245521, 32'o14164542224, 32'o32633236305,
        32'o23342700176, 32'o02433062234, 32'o15257225043, 32'o26762051606,
        32'o00742573230, 32'o05366042132, 32'o12126416411, 32'o00520471171,
        32'o00725646277, 32'o20116577576, 32'o25765742604, 32'o07633473735,
        32'o15674255275, 32'o17555634041, 32'o06503154145, 32'o21576344247,
        32'o14577627653, 32'o02707523333, 32'o34146376720, 32'o30060227734,
        32'o13765414060, 32'o36072251540, 32'o07255221037, 32'o24364674123,
        32'o06200353166, 32'o10126373326, 32'o15664104320, 32'o16401041535,
        32'o16215305520, 32'o33115351014, 32'o17411670323
    };

    // directed stimulus: either a seed write or a draw; want is used only when known
    typedef struct packed {
        logic        seed_write;
        logic [31:0] data;
        logic        known;
        logic [31:0] want;
    } stim_row_t;

    localparam stim_row_t DIRECTED [DIR_ROWS] = '{
        '{1'b0, 32'h0000_0000, 1'b0, 32'h0},   // raw sum straight after reset
        '{1'b0, 32'h0000_0001, 1'b1, 32'h0},   // anything mod 1 is 0
        '{1'b0, 32'h0000_0002, 1'b0, 32'h0},
        '{1'b0, 32'hFFFF_FFFF, 1'b0, 32'h0},
        '{1'b0, 32'h8000_0000, 1'b0, 32'h0},
        '{1'b0, 32'h0000_0000, 1'b0, 32'h0},
        '{1'b0, 32'h0000_0037, 1'b0, 32'h0},
        '{1'b0, 32'h0000_0001, 1'b1, 32'h0},
        '{1'b0, 32'h0000_0003, 1'b0, 32'h0},
        '{1'b1, 32'hFFFF_FFFF, 1'b0, 32'h0},   // all-ones seed
        '{1'b0, 32'h0000_0000, 1'b0, 32'h0},
        '{1'b0, 32'h0000_0001, 1'b1, 32'h0},
        '{1'b0, 32'hFFFF_FFFF, 1'b0, 32'h0},
        '{1'b0, 32'h0000_0007, 1'b0, 32'h0},
        '{1'b1, 32'h0000_0000, 1'b0, 32'h0},   // zero seed written back: chain starts at 0
        '{1'b0, 32'h0000_0000, 1'b0, 32'h0},
        '{1'b0, 32'h0000_0001, 1'b1, 32'h0},
        '{1'b0, 32'h7FFF_FFFF, 1'b0, 32'h0},
        '{1'b1, 32'h1234_5678, 1'b0, 32'h0},
        '{1'b0, 32'h0000_0000, 1'b0, 32'h0},
        '{1'b0, 32'h0000_0064, 1'b0, 32'h0}
    };

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic [DATA_W-1:0] cfg_wdata = '0;
    logic              draw_valid = 1'b0;
    logic              draw_ready;
    logic [DATA_W-1:0] bound = '0;
    logic              result_valid;
    logic              result_ready = 1'b0;
    logic [DATA_W-1:0] value;

    // model state
    logic [31:0] lag_words [N_WORDS];
    int          lead_pos;
    int          trail_pos;

    logic [31:0] pending_values [$];   // expected draw results, oldest first
    int          fail_count = 0;
    int          quiet_cycles = 0;
    int          burst_left = 1;
    bit          pacing_on = 1'b1;
    logic [15:0] rx_cyc = '0;

    additive_lagged_fibonacci_rng u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .draw_valid   (draw_valid),
        .draw_ready   (draw_ready),
        .bound        (bound),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .value        (value)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // rebuild the table from the fixed words and the seed chain
    function automatic void reseed_words(input logic [31:0] seed_val);
        logic [31:0] chain;
        chain = seed_val;
        lag_words[0] = SEED_WORDS[0] + seed_val;
        for (int i = 1; i < N_WORDS; i++)
        begin
            chain = lag_words[i-1] * 32'd1001 + chain * 32'd999;
            lag_words[i] = SEED_WORDS[i] + chain;
        end
        lead_pos  = int'(lag_words[0] % 32'(N_WORDS));
        trail_pos = (lead_pos + LAG_AHEAD) % N_WORDS;
    endfunction

    // one draw: lagged sum stored back at the lead slot, both slots step on
    function automatic logic [31:0] next_draw(input logic [31:0] modulus);
        logic [31:0] sum;
        sum = lag_words[lead_pos] + lag_words[trail_pos];
        lag_words[lead_pos] = sum;
        lead_pos  = (lead_pos + 1) % N_WORDS;
        trail_pos = (trail_pos + 1) % N_WORDS;
        return (modulus != 32'd0) ? sum % modulus : sum;
    endfunction

    // present one item, wait for acceptance, then record the expected value.
    // Valid stays high into the next item unless the burst ends here while pacing is on.
    task automatic send_draw(input logic [31:0] modulus, input logic known,
                             input logic [31:0] want);
        logic [31:0] predicted;
        int          gap;
        draw_valid <= 1'b1;
        bound      <= modulus;
        @(posedge clk);
        while (!draw_ready)
            @(posedge clk);
        predicted = next_draw(modulus);
        pending_values.push_back(known ? want : predicted);
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 40);
            if (pacing_on)
            begin
                gap = $urandom_range(1, 20);
                draw_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // seed writes must land only while idle (not enforced by the block): drain every result first
    task automatic load_seed(input logic [31:0] seed_val);
        draw_valid <= 1'b0;
        while (pending_values.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= seed_val;
        @(posedge clk);
        cfg_we <= 1'b0;
        reseed_words(seed_val);
    endtask

    // result side: check each accepted item, then set ready for the next edge.
    // The stall pattern cycles through four modes, picked by bits 8:7 of rx_cyc.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_values.size() == 0)
            begin
                $error("value: unexpected result %h with nothing pending", value);
                fail_count++;
            end
            else
            begin
                if (value !== pending_values[0])
                begin
                    $error("value mismatch: expected %h, actual %h",
                           pending_values[0], value);
                    fail_count++;
                end
                void'(pending_values.pop_front());
            end
        end
        rx_cyc <= rx_cyc + 16'd1;
        case (rx_cyc[8:7])
            2'd0: result_ready <= 1'b1;
            2'd1: result_ready <= (rx_cyc[1:0] == 2'd0);
            2'd2: result_ready <= 1'($urandom_range(0, 1));
            default: result_ready <= (rx_cyc[3:0] < 4'd12);
        endcase
    end

    // watchdog: too long with no handshake on any port ends the run
    always @(posedge clk)
    begin
        if ((draw_valid && draw_ready) || (result_valid && result_ready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] modulus;
        logic [31:0] seed_val;

        reseed_words(32'd0);   // reset value of the seed register
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        for (int r = 0; r < DIR_ROWS; r++)
        begin
            if (DIRECTED[r].seed_write)
                load_seed(DIRECTED[r].data);
            else
                send_draw(DIRECTED[r].data, DIRECTED[r].known, DIRECTED[r].want);
        end

        // random phases, each under a fresh seed; one phase runs with no sender gaps
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: seed_val = 32'hFFFF_FFFF;
                1: seed_val = 32'h0000_0000;
                default: seed_val = $urandom;
            endcase
            load_seed(seed_val);
            pacing_on = (p != 2);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                case ($urandom_range(0, 9))
                    0, 1: modulus = 32'd0;
                    2, 3: modulus = $urandom_range(1, 64);
                    4: modulus = 32'd1 << $urandom_range(0, 31);
                    5: modulus = 32'hFFFF_FFFF - $urandom_range(0, 15);
                    6: modulus = $urandom >> $urandom_range(0, 31);
                    default: modulus = $urandom;
                endcase
                send_draw(modulus, 1'b0, 32'd0);
            end
        end

        draw_valid <= 1'b0;
        while (pending_values.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
